// ===== rtl/sssc_pkg.sv =====
package sssc_pkg;

    localparam int DIGITS = 4;
    localparam int DW     = $clog2(DIGITS);

    // APB register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_COMMON_ANODE = 2'd0;
    localparam logic [1:0] REG_SCAN_PERIOD  = 2'd1;
    localparam logic [1:0] REG_BLINK_SCANS  = 2'd2;

    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_ZERO  = 8'h3F;
    localparam logic [7:0] SEG_DOT   = 8'h80;

    // 2^35 / 10, rounded up: exact quotient for any 32-bit value
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

    typedef enum logic [2:0] {
        MODE_TICK      = 3'd0,
        MODE_RAW       = 3'd1,
        MODE_INT       = 3'd2,
        MODE_INT_DOT   = 3'd3,
        MODE_TIME      = 3'd4,
        MODE_BLINK_ON  = 3'd5,
        MODE_BLINK_OFF = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIG,
        ST_LZ,
        ST_DOT
    } t_state;

    typedef struct packed {
        logic       common_anode;
        logic [7:0] scan_period;
        logic [7:0] blink_scans;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic raw_wr;
        logic time_wr;
        logic blink_on;
        logic blink_off;
        logic int_load;
        logic with_dot;
        logic mul;
        logic dig_wr;
        logic lz_step;
        logic dot_wr;
    } t_cmd;

    typedef struct packed {
        logic idx_zero;
        logic idx_lz_last;
        logic dot_en;
        logic dot_ok;
        logic out_blocked;
    } t_status;

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h27;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] sat99(input logic [6:0] v);
        return (v > 7'd99) ? 7'd99 : v;
    endfunction

    // tens digit of a value up to 99: v * 205 / 2048
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] ones_of(input logic [6:0] v);
        logic [6:0] t;
        t = 7'(tens_of(v)) * 7'd10;
        return 4'(v - t);
    endfunction

endpackage

// ===== rtl/sssc_div10.sv =====
module sssc_div10
    import sssc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [31:0] i_value,
    input  logic        i_mul,
    input  logic        i_step,
    output logic [3:0]  o_digit
);

    logic [31:0] r_val;
    logic [28:0] r_q;
    logic [63:0] w_prod;
    logic [31:0] w_q10;
    logic [31:0] w_rem;

    assign w_prod  = 64'(r_val) * 64'(RECIP_TEN);
    assign w_q10   = (32'(r_q) << 3) + (32'(r_q) << 1);
    assign w_rem   = r_val - w_q10;
    assign o_digit = w_rem[3:0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= i_value;
        end else if (i_step) begin
            r_val <= 32'(r_q);
        end
        if (i_mul) begin
            r_q <= w_prod[63:35];
        end
    end

endmodule

// ===== rtl/sssc_dpath.sv =====
module sssc_dpath
    import sssc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    output t_status     o_st,
    input  logic [2:0]  i_digit_index,
    input  logic [31:0] i_number,
    input  logic [2:0]  i_dot_position,
    input  logic [6:0]  i_hours,
    input  logic [6:0]  i_minutes,
    input  logic [6:0]  i_seconds,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [7:0]  o_segment_drive,
    output logic [2:0]  o_digit_select
);

    logic [7:0]    r_buf [DIGITS];
    logic [7:0]    n_buf [DIGITS];
    logic [DIGITS-1:0] r_blink_en, n_blink_en;
    logic [DIGITS-1:0] r_phase_off, n_phase_off;
    logic [DW-1:0] r_scan;
    logic [7:0]    r_ms, r_bc;
    logic [DW-1:0] r_idx;
    logic [DW-1:0] r_dot;
    logic          r_dot_en;
    logic          r_stop;
    logic          r_out_valid;
    logic [7:0]    r_seg;
    logic [DW-1:0] r_sel;

    logic [DW-1:0] w_rd_addr;
    logic [7:0]    w_rd;
    logic [7:0]    w_mask;
    logic          w_di_ok;
    logic [DW-1:0] w_di;
    logic [7:0]    w_ms_inc, w_bc_inc;
    logic          w_fire, w_toggle;
    logic [3:0]    w_digit;
    logic [6:0]    w_hh, w_mm, w_ss;
    logic [7:0]    w_slot_seg;

    sssc_div10 u_div10 (
        .i_clk   (i_clk),
        .i_load  (i_cmd.int_load),
        .i_value (i_number),
        .i_mul   (i_cmd.mul),
        .i_step  (i_cmd.dig_wr),
        .o_digit (w_digit)
    );

    assign w_mask    = i_cfg.common_anode ? 8'hFF : 8'h00;
    assign w_di      = i_digit_index[DW-1:0];
    assign w_di_ok   = {1'b0, i_digit_index} < 4'(DIGITS);
    assign w_rd_addr = i_cmd.lz_step ? r_idx : (i_cmd.dot_wr ? r_dot : r_scan);
    assign w_rd      = r_buf[w_rd_addr];
    assign w_ms_inc  = r_ms + 8'd1;
    assign w_bc_inc  = r_bc + 8'd1;
    assign w_fire    = i_cmd.tick && (w_ms_inc >= i_cfg.scan_period);
    assign w_toggle  = w_bc_inc >= i_cfg.blink_scans;
    assign w_hh      = sat99(i_hours);
    assign w_mm      = sat99(i_minutes);
    assign w_ss      = sat99(i_seconds);
    assign w_slot_seg = (r_blink_en[r_scan] && r_phase_off[r_scan]) ? SEG_BLANK : w_rd;

    assign o_st.idx_zero    = (r_idx == '0);
    assign o_st.idx_lz_last = (r_idx == DW'(DIGITS - 2));
    assign o_st.dot_en      = r_dot_en;
    assign o_st.dot_ok      = (i_dot_position != 3'd0) && ({1'b0, i_dot_position} < 4'(DIGITS));
    assign o_st.out_blocked = r_out_valid && i_out_stall;

    always_comb begin
        n_buf       = r_buf;
        n_blink_en  = r_blink_en;
        n_phase_off = r_phase_off;
        if (i_cmd.raw_wr && w_di_ok) begin
            n_buf[w_di] = i_number[7:0] ^ w_mask;
        end
        if (i_cmd.time_wr) begin
            n_buf[DW'(0)] = (tens_of(w_hh) != 4'd0) ? seg_code(tens_of(w_hh)) : SEG_BLANK;
            n_buf[DW'(1)] = seg_code(ones_of(w_hh));
            n_buf[DW'(2)] = seg_code(tens_of(w_mm));
            n_buf[DW'(3)] = seg_code(ones_of(w_mm));
            if (DIGITS >= 6) begin
                n_buf[DW'(4 % DIGITS)] = seg_code(tens_of(w_ss));
                n_buf[DW'(5 % DIGITS)] = seg_code(ones_of(w_ss));
            end
        end
        if (i_cmd.dig_wr) begin
            n_buf[r_idx] = seg_code(w_digit);
        end
        if (i_cmd.lz_step && !r_stop && (w_rd == SEG_ZERO)) begin
            n_buf[r_idx] = SEG_BLANK;
        end
        if (i_cmd.dot_wr) begin
            n_buf[r_dot] = w_rd | SEG_DOT;
        end
        if (i_cmd.blink_on && w_di_ok) begin
            n_blink_en[w_di]  = 1'b1;
            n_phase_off[w_di] = 1'b1;
        end
        if (i_cmd.blink_off && w_di_ok) begin
            n_blink_en[w_di]  = 1'b0;
            n_phase_off[w_di] = 1'b0;
        end
        if (w_fire && w_toggle) begin
            n_phase_off = n_phase_off ^ r_blink_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGITS; i++) begin
                r_buf[i] <= SEG_BLANK;
            end
            r_blink_en  <= '0;
            r_phase_off <= '0;
            r_scan      <= '0;
            r_ms        <= '0;
            r_bc        <= '0;
            r_idx       <= '0;
            r_dot_en    <= 1'b0;
            r_stop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_buf       <= n_buf;
            r_blink_en  <= n_blink_en;
            r_phase_off <= n_phase_off;
            if (i_cmd.tick) begin
                r_ms <= w_fire ? 8'd0 : w_ms_inc;
            end
            if (w_fire) begin
                r_scan <= (r_scan == DW'(DIGITS - 1)) ? '0 : r_scan + 1'b1;
                r_bc   <= w_toggle ? 8'd0 : w_bc_inc;
            end
            if (i_cmd.int_load) begin
                r_idx    <= DW'(DIGITS - 1);
                r_dot_en <= i_cmd.with_dot;
            end else if (i_cmd.dig_wr) begin
                if (r_idx == '0) begin
                    r_stop <= 1'b0;
                end else begin
                    r_idx <= r_idx - 1'b1;
                end
            end else if (i_cmd.lz_step) begin
                r_idx <= r_idx + 1'b1;
                if (r_stop || (w_rd != SEG_ZERO)) begin
                    r_stop <= 1'b1;
                end
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.int_load) begin
            r_dot <= i_dot_position[DW-1:0];
        end
        if (w_fire) begin
            r_seg <= w_slot_seg ^ w_mask;
            r_sel <= r_scan;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_segment_drive = r_seg;
    assign o_digit_select  = 3'(r_sel);

endmodule

// ===== rtl/sssc_ctrl.sv =====
module sssc_ctrl
    import sssc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_mode,
    input  t_status    i_st,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    t_mode  w_mode;
    logic   w_acc;

    assign w_mode     = t_mode'(i_mode);
    assign o_in_stall = (r_state != ST_IDLE) || ((w_mode == MODE_TICK) && i_st.out_blocked);
    assign w_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && ((w_mode == MODE_INT) ||
                              ((w_mode == MODE_INT_DOT) && i_st.dot_ok))) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_DIG;
            ST_DIG: n_state = i_st.idx_zero ? ST_LZ : ST_MUL;
            ST_LZ: begin
                if (i_st.idx_lz_last) begin
                    n_state = i_st.dot_en ? ST_DOT : ST_IDLE;
                end
            end
            ST_DOT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (w_mode)
                        MODE_TICK:      o_cmd.tick      = 1'b1;
                        MODE_RAW:       o_cmd.raw_wr    = 1'b1;
                        MODE_INT:       o_cmd.int_load  = 1'b1;
                        MODE_INT_DOT: begin
                            o_cmd.int_load = i_st.dot_ok;
                            o_cmd.with_dot = 1'b1;
                        end
                        MODE_TIME:      o_cmd.time_wr   = 1'b1;
                        MODE_BLINK_ON:  o_cmd.blink_on  = 1'b1;
                        MODE_BLINK_OFF: o_cmd.blink_off = 1'b1;
                        default:        o_cmd = '0;
                    endcase
                end
            end
            ST_MUL:  o_cmd.mul     = 1'b1;
            ST_DIG:  o_cmd.dig_wr  = 1'b1;
            ST_LZ:   o_cmd.lz_step = 1'b1;
            ST_DOT:  o_cmd.dot_wr  = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/seven_segment_scan_controller_core.sv =====
// Ticks, raw, time and blink transfers act directly on acceptance; a tick that ends a slot
// has its result in the output register from the cycle after acceptance.
// Integer writes run the shared divide-by-ten unit (multiply, then digit write) for
// each digit, then the leading-zero pass, then a dot write when a dot is set.
// Reset (i_rst_n, synchronous, active low): buffer blank, blink off, counters
// zero, registers at common cathode, scan period 2, blink scans 250.
module seven_segment_scan_controller_core
    import sssc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_mode,
    input  logic [2:0]         i_digit_index,
    input  logic [31:0]        i_number,
    input  logic [2:0]         i_dot_position,
    input  logic [6:0]         i_hours,
    input  logic [6:0]         i_minutes,
    input  logic [6:0]         i_seconds,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_segment_drive,
    output logic [2:0]         o_digit_select,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    t_status w_st;
    logic    w_wr;
    logic [1:0] w_reg;

    // APB: zero wait states, write lands on the access phase
    assign pready = 1'b1;
    assign w_reg  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.common_anode <= 1'b0;
            r_cfg.scan_period  <= 8'd2;
            r_cfg.blink_scans  <= 8'd250;
        end else if (w_wr) begin
            case (w_reg)
                REG_COMMON_ANODE: r_cfg.common_anode <= pwdata[0];
                REG_SCAN_PERIOD:  r_cfg.scan_period  <= pwdata[7:0];
                REG_BLINK_SCANS:  r_cfg.blink_scans  <= pwdata[7:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_COMMON_ANODE: prdata = {31'd0, r_cfg.common_anode};
            REG_SCAN_PERIOD:  prdata = {24'd0, r_cfg.scan_period};
            REG_BLINK_SCANS:  prdata = {24'd0, r_cfg.blink_scans};
            default:          prdata = 32'd0;
        endcase
    end

    // sequencer: decodes the accepted transfer and steps integer conversion
    sssc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_st       (w_st),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // buffers, blink state, scan counters and the output register
    sssc_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (w_cmd),
        .o_st            (w_st),
        .i_digit_index   (i_digit_index),
        .i_number        (i_number),
        .i_dot_position  (i_dot_position),
        .i_hours         (i_hours),
        .i_minutes       (i_minutes),
        .i_seconds       (i_seconds),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_segment_drive (o_segment_drive),
        .o_digit_select  (o_digit_select)
    );

endmodule
